// File: sv/bam_pkg.sv
`timescale 1ns / 1ps

package bam_pkg;

  // Store geometry
  localparam int unsigned WordCount  = 65536;
  localparam int unsigned IdxW       = $clog2(WordCount);
  localparam logic [32:0] TotalBytes = 33'(WordCount) * 33'd4;

  typedef enum logic [1:0] {
    KIND_IDLE  = 2'd0,
    KIND_READ  = 2'd1,
    KIND_WRITE = 2'd2,
    KIND_BOTH  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    SIZE_BYTE = 2'd0,
    SIZE_HALF = 2'd1,
    SIZE_WORD = 2'd2,
    SIZE_BAD  = 2'd3
  } size_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_READY,
    ST_MODIFY
  } state_e;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] address;
    size_e       access_size;
    logic        sext;
    logic [31:0] wr_data;
  } req_t;

  typedef struct packed {
    logic [31:0] rd_data;
    logic        fault;
    logic        data_valid;
  } rsp_t;

  // Lane unit result: write-back control plus the response beat
  typedef struct packed {
    logic        we;
    logic [31:0] wdata;
    rsp_t        rsp;
  } lane_t;

endpackage

// File: sv/byte_addressed_data_memory_top.sv
`timescale 1ns / 1ps
// Byte-addressed data memory: 65536 words of 32 bits, little-endian.
//
// Input channel (in_valid_i / in_stall_o / in_req_i): one access per beat,
// idle, read, write or both, with byte address, size and sign-extend flag.
// Output channel (out_valid_o / out_stall_i / out_rsp_o): one response beat
// per access, carrying the addressed value after any write of that access,
// a fault flag and a data-valid flag.
//
// Each access is a read-modify-write on a single-port synchronous RAM: the
// word is read in ST_READY as the beat is accepted, then merged and, for a
// legal write, written back in ST_MODIFY once the output register is free;
// no new access is taken before that commit, which also loads the response.
//
// After reset a clearing pass writes zero to every word, one word a cycle;
// in_stall_o stays high until it finishes.
// The response sits in an output register: a stalled receiver holds it, and
// the block still accepts and reads the next access, then waits with the
// merged word unwritten until the register frees up.
module byte_addressed_data_memory_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  bam_pkg::req_t in_req_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output bam_pkg::rsp_t out_rsp_o
);

  bam_pkg::state_e            state_q, state_d;
  logic [bam_pkg::IdxW-1:0]   clr_q, clr_d;
  logic                       clr_last;
  logic                       out_valid_q, out_valid_d;
  bam_pkg::req_t              req_q;
  bam_pkg::rsp_t              rsp_q;

  logic                       in_take;
  logic                       out_free;
  logic                       commit;
  logic                       ram_en;
  logic                       ram_we;
  logic [bam_pkg::IdxW-1:0]   ram_addr;
  logic [31:0]                ram_wdata;
  logic [31:0]                ram_rdata;
  bam_pkg::lane_t             lane;

  assign clr_last = (clr_q == bam_pkg::IdxW'(bam_pkg::WordCount - 1));
  assign in_take  = in_valid_i & ~in_stall_o;
  assign out_free = ~out_valid_q | ~out_stall_i;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      bam_pkg::ST_CLEAR: begin
        if (clr_last) state_d = bam_pkg::ST_READY;
      end
      bam_pkg::ST_READY: begin
        if (in_valid_i) state_d = bam_pkg::ST_MODIFY;
      end
      bam_pkg::ST_MODIFY: begin
        if (out_free) state_d = bam_pkg::ST_READY;
      end
      default: state_d = bam_pkg::ST_CLEAR;
    endcase
  end

  // Outputs of the sequencer: RAM port and handshake
  always_comb begin
    in_stall_o = 1'b1;
    commit     = 1'b0;
    ram_en     = 1'b0;
    ram_we     = 1'b0;
    ram_addr   = clr_q;
    ram_wdata  = 32'd0;
    case (state_q)
      bam_pkg::ST_CLEAR: begin
        // zero one word per cycle
        ram_en = 1'b1;
        ram_we = 1'b1;
      end
      bam_pkg::ST_READY: begin
        // read the addressed word as the beat is taken
        in_stall_o = 1'b0;
        ram_en     = in_valid_i;
        ram_addr   = in_req_i.address[bam_pkg::IdxW+1:2];
      end
      bam_pkg::ST_MODIFY: begin
        // write back a legal write and load the response once the output register frees
        commit    = out_free;
        ram_en    = out_free & lane.we;
        ram_we    = 1'b1;
        ram_addr  = req_q.address[bam_pkg::IdxW+1:2];
        ram_wdata = lane.wdata;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  assign clr_d       = (state_q == bam_pkg::ST_CLEAR) ? clr_q + 1'b1 : clr_q;
  assign out_valid_d = commit | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bam_pkg::ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: hold the taken beat and the pending response
  always_ff @(posedge clk_i) begin
    if (in_take) req_q <= in_req_i;
    if (commit)  rsp_q <= lane.rsp;
  end

  bam_ram #(
    .Width (32),
    .Depth (bam_pkg::WordCount)
  ) u_ram (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  bam_lane u_lane (
    .req_i  (req_q),
    .word_i (ram_rdata),
    .lane_o (lane)
  );

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

endmodule

// File: sv/bam_ram.sv
`timescale 1ns / 1ps

module bam_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [Width-1:0] wdata_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Single port; read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/bam_lane.sv
`timescale 1ns / 1ps

module bam_lane (
  input  bam_pkg::req_t  req_i,
  input  logic [31:0]    word_i,
  output bam_pkg::lane_t lane_o
);

  logic        aligned;
  logic        in_range;
  logic        legal;
  logic [1:0]  lane;
  logic [4:0]  shift;
  logic [3:0]  byte_en;
  logic [31:0] mask;
  logic [31:0] placed;
  logic [31:0] merged;
  logic [31:0] raw;
  logic [31:0] extended;

  assign lane  = req_i.address[1:0];
  assign shift = {lane, 3'b000};

  always_comb begin
    case (req_i.access_size)
      bam_pkg::SIZE_BYTE: begin
        aligned = 1'b1;
        byte_en = 4'b0001 << lane;
      end
      bam_pkg::SIZE_HALF: begin
        aligned = (lane[0] == 1'b0);
        byte_en = 4'b0011 << lane;
      end
      bam_pkg::SIZE_WORD: begin
        aligned = (lane == 2'b00);
        byte_en = 4'b1111;
      end
      default: begin
        aligned = 1'b0;
        byte_en = 4'b0000;
      end
    endcase
  end

  // An aligned access that starts inside the store also ends inside it
  assign in_range = ({1'b0, req_i.address} < bam_pkg::TotalBytes);
  assign legal    = aligned & in_range;

  assign mask   = {{8{byte_en[3]}}, {8{byte_en[2]}}, {8{byte_en[1]}}, {8{byte_en[0]}}};
  assign placed = (req_i.wr_data << shift) & mask;
  // Merge the new bytes only for a write; reads and idles see the stored word
  assign merged = req_i.kind[1] ? ((word_i & ~mask) | placed) : word_i;
  assign raw    = (merged & mask) >> shift;

  always_comb begin
    case (req_i.access_size)
      bam_pkg::SIZE_BYTE: extended = {{24{req_i.sext & raw[7]}}, raw[7:0]};
      bam_pkg::SIZE_HALF: extended = {{16{req_i.sext & raw[15]}}, raw[15:0]};
      default:            extended = raw;
    endcase
  end

  assign lane_o.we             = legal & req_i.kind[1];
  assign lane_o.wdata          = merged;
  assign lane_o.rsp.rd_data    = legal ? extended : 32'd0;
  assign lane_o.rsp.fault      = (req_i.kind != bam_pkg::KIND_IDLE) & ~legal;
  assign lane_o.rsp.data_valid = legal;

endmodule

// File: sv/bam_checker.sv
`timescale 1ns / 1ps

module bam_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_stall_o,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input bam_pkg::rsp_t out_rsp_o
);

  // A stalled response beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("stalled response beat changed");

  // One access at a time: a taken beat closes the input for the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input open in the cycle after an accept");

  // A faulting access never reports readable data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_rsp_o.fault && out_rsp_o.data_valid))
    else $error("fault and data_valid both set");

  // An illegal access returns zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_rsp_o.data_valid |-> out_rsp_o.rd_data == 32'd0)
    else $error("nonzero data on an illegal access");

endmodule

bind byte_addressed_data_memory_top bam_checker u_bam_checker (.*);
